[sv/s2dc_pkg.sv]
// Package for the strided 2-D convolution core: shared types, register
// indexes, sequencer states and the stride reciprocal table.
// No dependencies.
package s2dc_pkg;

    localparam int KDIM      = 3;      // window rows and columns
    localparam int PAD_MAX   = 62;     // padded row length (60 + 2)
    localparam int MAX_WIDTH = 60;
    localparam int MAX_RES   = 64;     // results kept per input beat
    localparam int DIV_K     = 17;     // reciprocal scale, 2**17

    localparam logic [10:0] ROW_SAT = 11'd1025;

    typedef enum logic [2:0] {
        CFG_KROW_TOP = 3'd0,
        CFG_KROW_MID = 3'd1,
        CFG_KROW_LOW = 3'd2,
        CFG_KHEIGHT  = 3'd3,
        CFG_KWIDTH   = 3'd4,
        CFG_STEP     = 3'd5,
        CFG_BORDER   = 3'd6,
        CFG_IWIDTH   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_LEFT,
        ST_PIX,
        ST_FILL,
        ST_RIGHT,
        ST_BOTTOM
    } t_state;

    // One padded pixel handed from the sequencer to the datapath.
    typedef struct packed {
        logic        vld;
        logic [7:0]  pix;
        logic [10:0] y;
        logic [5:0]  x;
        logic        last;
        logic        fend;
    } t_feed;

    typedef struct packed {
        logic [27:0] value;
        logic [9:0]  out_row;
        logic [5:0]  out_col;
        logic        run_last;
        logic        image_done;
    } t_res;

    // ceil(2**17 / s); exact quotient for numerators up to 1025.
    localparam logic [17:0] RECIP_TBL [64] = '{
        18'd131072, 18'd131072, 18'd65536, 18'd43691, 18'd32768, 18'd26215,
        18'd21846,  18'd18725,  18'd16384, 18'd14564, 18'd13108, 18'd11916,
        18'd10923,  18'd10083,  18'd9363,  18'd8739,  18'd8192,  18'd7711,
        18'd7282,   18'd6899,   18'd6554,  18'd6242,  18'd5958,  18'd5699,
        18'd5462,   18'd5243,   18'd5042,  18'd4855,  18'd4682,  18'd4520,
        18'd4370,   18'd4229,   18'd4096,  18'd3972,  18'd3856,  18'd3745,
        18'd3641,   18'd3543,   18'd3450,  18'd3361,  18'd3277,  18'd3197,
        18'd3121,   18'd3049,   18'd2979,  18'd2913,  18'd2850,  18'd2789,
        18'd2731,   18'd2675,   18'd2622,  18'd2571,  18'd2521,  18'd2474,
        18'd2428,   18'd2384,   18'd2341,  18'd2300,  18'd2260,  18'd2222,
        18'd2185,   18'd2149,   18'd2115,  18'd2081
    };

endpackage

[sv/s2dc_if.sv]
// Valid/ready channel interfaces for the pixel input and the result output.
// No dependencies.
interface s2dc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_end;

    modport source (output valid, output pixel, output frame_end, input ready);
    modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

interface s2dc_res_if;
    logic        valid;
    logic        ready;
    logic [27:0] value;
    logic [9:0]  out_row;
    logic [5:0]  out_col;
    logic        run_last;
    logic        image_done;

    modport source (output valid, output value, output out_row, output out_col,
                    output run_last, output image_done, input ready);
    modport sink   (input valid, input value, input out_row, input out_col,
                    input run_last, input image_done, output ready);
endinterface

[sv/strided_2d_convolution_core.sv]
// Strided 2-D convolution core, up to 3x3 kernel, Q4.12 coefficients.
// Each result is held until the next result or the end of its input beat so
// run_last can be marked. One padded-pixel feed is issued per cycle while the
// pipeline advances; a pixel beat issues its pixel feed plus one feed per
// border zero and fill pixel, a full padded row (width + 2) per top or bottom
// border row. Sync active-low reset clears control, config and window cells.
module strided_2d_convolution_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    s2dc_pix_if.sink             i_pix,
    s2dc_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [47:0]          i_cfg_data
);
    import s2dc_pkg::*;

    // Configuration registers
    logic [2:0][47:0] r_krow;
    logic [1:0]       r_kh, r_kw;
    logic [5:0]       r_step, r_width;
    logic             r_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_krow  <= '0;
            r_kh    <= 2'd1;
            r_kw    <= 2'd1;
            r_step  <= 6'd1;
            r_pad   <= 1'b0;
            r_width <= 6'd60;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KROW_TOP: r_krow[0] <= i_cfg_data;
                CFG_KROW_MID: r_krow[1] <= i_cfg_data;
                CFG_KROW_LOW: r_krow[2] <= i_cfg_data;
                CFG_KHEIGHT:  r_kh      <= i_cfg_data[1:0];
                CFG_KWIDTH:   r_kw      <= i_cfg_data[1:0];
                CFG_STEP:     r_step    <= i_cfg_data[5:0];
                CFG_BORDER:   r_pad     <= i_cfg_data[0];
                CFG_IWIDTH:   r_width   <= i_cfg_data[5:0];
                default:      ;
            endcase
        end
    end

    // Zero reads as one; an input width above the maximum clamps to it.
    logic [1:0] kh, kw;
    logic [5:0] s_cl, w_cl;
    assign kh   = (r_kh == 2'd0) ? 2'd1 : r_kh;
    assign kw   = (r_kw == 2'd0) ? 2'd1 : r_kw;
    assign s_cl = (r_step == 6'd0) ? 6'd1 : r_step;
    assign w_cl = (r_width == 6'd0) ? 6'd1 :
                  (r_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : r_width;

    // Global advance: the whole pipeline moves only when the output slot
    // can take a beat and no end-of-beat result is still parked.
    logic   out_free, en;
    logic   r_pend_fin;
    logic   r_ovld;
    assign out_free = !r_ovld || o_res.ready;
    assign en       = out_free && !r_pend_fin;

    // Sequencer
    logic  seq_ready, acc;
    t_feed feed;
    assign acc         = i_pix.valid && seq_ready;
    assign i_pix.ready = seq_ready;

    s2dc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_pixel     (i_pix.pixel),
        .i_frame_end (i_pix.frame_end),
        .i_adv       (en),
        .i_pad       (r_pad),
        .i_width     (w_cl),
        .o_ready     (seq_ready),
        .o_feed      (feed)
    );

    // Stage 1: issue the line store read, compute window corner position.
    logic        r1_vld, r1_last, r1_fend, r1_ok;
    logic [7:0]  r1_pix;
    logic [5:0]  r1_x, r1_j;
    logic [10:0] r1_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= feed.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pix  <= feed.pix;
            r1_x    <= feed.x;
            r1_last <= feed.last;
            r1_fend <= feed.fend;
            r1_ok   <= ({1'b0, feed.y} + 12'd1 >= {10'd0, kh}) &&
                       ({1'b0, feed.x} + 7'd1 >= {5'd0, kw});
            r1_i    <= 11'(feed.y + 11'd1 - {9'd0, kh});
            r1_j    <= 6'(feed.x + 6'd1 - {4'd0, kw});
        end
    end

    // Line store: two rows per address, row 0 low byte, row 1 high byte.
    // Valid bits stand in for the zero reset; a same-address write in the
    // read cycle is forwarded.
    logic [15:0] mem [PAD_MAX];
    logic [PAD_MAX-1:0] r_mvld;
    logic [15:0] r_rd, r_fwd_d, rd_eff, wdata;
    logic        r_rd_vld, r_fwd;

    always_comb begin
        if (r_fwd)         rd_eff = r_fwd_d;
        else if (r_rd_vld) rd_eff = r_rd;
        else               rd_eff = 16'd0;
    end
    assign wdata = {r1_pix, rd_eff[15:8]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd     <= mem[feed.x];
            r_rd_vld <= r_mvld[feed.x];
            r_fwd    <= r1_vld && (r1_x == feed.x);
            r_fwd_d  <= wdata;
            if (r1_vld) mem[r1_x] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= '0;
        end else if (en && r1_vld) begin
            r_mvld[r1_x] <= 1'b1;
        end
    end

    // Window: three column cells, new column enters at the right end.
    logic [2:0][2:0][15:0] coef;   // [column][row]
    logic [2:0][2:0][7:0]  wcol;
    logic [2:0][2:0][24:0] prod;
    logic [2:0][2:0][7:0]  cell_in;

    always_comb begin
        logic [1:0] rr, cc;
        coef = '0;
        for (int wr = 0; wr < KDIM; wr++) begin
            for (int wc = 0; wc < KDIM; wc++) begin
                rr = 2'(wr + int'(kh) - KDIM);
                cc = 2'(wc + int'(kw) - KDIM);
                if (wr + int'(kh) >= KDIM && wc + int'(kw) >= KDIM) begin
                    coef[wc][wr] = r_krow[rr][16*cc +: 16];
                end
            end
        end
    end

    assign cell_in[2] = {r1_pix, rd_eff[15:8], rd_eff[7:0]};
    assign cell_in[1] = wcol[2];
    assign cell_in[0] = wcol[1];

    for (genvar c = 0; c < KDIM; c++) begin : g_cell
        s2dc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ld    (r1_vld),
            .i_col   (cell_in[c]),
            .i_coef  (coef[c]),
            .o_col   (wcol[c]),
            .o_prod  (prod[c])
        );
    end

    // Stages 2-4: stride test by reciprocal multiply, sum of products.
    logic        r2_vld, r2_last, r2_fend, r2_ok;
    logic [10:0] r2_i;
    logic [5:0]  r2_j;
    logic [28:0] r2_pi;
    logic [23:0] r2_pj;
    logic        r3_vld, r3_last, r3_fend, r3_ok;
    logic [10:0] r3_i, r3_qi;
    logic [5:0]  r3_j, r3_qj;
    logic        r4_vld, r4_last, r4_fend, r4_emit;
    logic [10:0] r4_qi;
    logic [5:0]  r4_qj;
    logic [27:0] r4_value;
    logic signed [28:0] psum;

    always_comb begin
        psum = '0;
        for (int c = 0; c < KDIM; c++) begin
            for (int r = 0; r < KDIM; r++) begin
                psum = psum + 29'($signed(prod[c][r]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_last  <= r1_last;
            r2_fend  <= r1_fend;
            r2_ok    <= r1_ok;
            r2_i     <= r1_i;
            r2_j     <= r1_j;
            r2_pi    <= r1_i * RECIP_TBL[s_cl];
            r2_pj    <= r1_j * RECIP_TBL[s_cl];
            r3_last  <= r2_last;
            r3_fend  <= r2_fend;
            r3_ok    <= r2_ok;
            r3_i     <= r2_i;
            r3_j     <= r2_j;
            r3_qi    <= r2_pi[DIV_K+10:DIV_K];
            r3_qj    <= r2_pj[DIV_K+5:DIV_K];
            r4_last  <= r3_last;
            r4_fend  <= r3_fend;
            r4_qi    <= r3_qi;
            r4_qj    <= r3_qj;
            r4_emit  <= r3_vld && r3_ok &&
                        (r3_i == 11'(r3_qi * s_cl)) && (r3_j == 6'(r3_qj * s_cl));
            r4_value <= psum[27:0];
        end
    end

    // Output: hold the newest result back until it is known whether it
    // ends its beat; drop anything past the per-beat limit.
    t_res       r_out, r_pend, res_new;
    logic       r_pend_vld;
    logic [6:0] r_cnt;
    logic       take;

    assign res_new = '{value: r4_value, out_row: r4_qi[9:0], out_col: r4_qj,
                       run_last: 1'b0, image_done: 1'b0};
    assign take    = r4_vld && r4_emit && (r_cnt < 7'(MAX_RES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_pend_fin <= 1'b0;
            r_cnt      <= '0;
        end else if (out_free) begin
            r_ovld <= 1'b0;
            if (r_pend_fin) begin
                r_ovld     <= 1'b1;
                r_pend_vld <= 1'b0;
                r_pend_fin <= 1'b0;
            end else if (r4_vld && r4_last) begin
                r_cnt <= '0;
                if (take) begin
                    r_ovld <= 1'b1;
                    if (r_pend_vld) r_pend_fin <= 1'b1;
                end else begin
                    r_ovld     <= r_pend_vld;
                    r_pend_vld <= 1'b0;
                end
            end else if (take) begin
                r_cnt      <= r_cnt + 7'd1;
                r_ovld     <= r_pend_vld;
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_fin) begin
                r_out <= r_pend;
            end else if (r4_vld && r4_last) begin
                if (take && r_pend_vld) begin
                    r_out  <= r_pend;
                    r_pend <= '{value: r4_value, out_row: r4_qi[9:0], out_col: r4_qj,
                                run_last: 1'b1, image_done: r4_fend};
                end else if (take) begin
                    r_out <= '{value: r4_value, out_row: r4_qi[9:0], out_col: r4_qj,
                               run_last: 1'b1, image_done: r4_fend};
                end else begin
                    r_out <= '{value: r_pend.value, out_row: r_pend.out_row,
                               out_col: r_pend.out_col, run_last: 1'b1,
                               image_done: r4_fend};
                end
            end else if (take) begin
                r_out  <= r_pend;
                r_pend <= res_new;
            end
        end
    end

    assign o_res.valid      = r_ovld;
    assign o_res.value      = r_out.value;
    assign o_res.out_row    = r_out.out_row;
    assign o_res.out_col    = r_out.out_col;
    assign o_res.run_last   = r_out.run_last;
    assign o_res.image_done = r_out.image_done;
endmodule

[sv/s2dc_cell.sv]
// One window column cell: holds three pixels, hands them to its left
// neighbor on each feed and registers the three coefficient products.
module s2dc_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_ld,
    input  logic [2:0][7:0]  i_col,
    input  logic [2:0][15:0] i_coef,
    output logic [2:0][7:0]  o_col,
    output logic [2:0][24:0] o_prod
);
    logic [2:0][7:0]  r_col;
    logic [2:0][24:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_en && i_ld) begin
            r_col <= i_col;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[k] <= $signed(i_coef[k]) * $signed({1'b0, r_col[k]});
            end
        end
    end

    assign o_col  = r_col;
    assign o_prod = r_prod;
endmodule

[sv/s2dc_seq.sv]
// Sequencer: expands each input beat into padded-pixel feeds (top row,
// left zero, pixel, fill, right zero, bottom row). Uses s2dc_pkg.
module s2dc_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  logic [7:0]       i_pixel,
    input  logic             i_frame_end,
    input  logic             i_adv,
    input  logic             i_pad,
    input  logic [5:0]       i_width,
    output logic             o_ready,
    output s2dc_pkg::t_feed  o_feed
);
    import s2dc_pkg::*;

    t_state      r_state, n0_state, n_state;
    logic [10:0] r_row, n0_row, n_row;
    logic [5:0]  r_col, n0_col, n_col;
    logic [5:0]  r_x, n0_x, n_x;
    logic [7:0]  r_pix, n_pix;
    logic        r_fend, n_fend;
    logic [5:0]  pw_m1;
    logic [5:0]  col1;
    logic        row_done;

    assign pw_m1 = i_width + {4'd0, i_pad, 1'b0} - 6'd1;
    assign col1  = r_col + 6'd1;

    // Advance the step in progress.
    always_comb begin
        n0_state = r_state;
        n0_row   = r_row;
        n0_col   = r_col;
        n0_x     = r_x;
        row_done = 1'b0;
        if (r_state != ST_IDLE && i_adv) begin
            case (r_state)
                ST_TOP: begin
                    if (r_x == pw_m1) begin
                        n0_row   = 11'd1;
                        n0_state = ST_LEFT;
                    end else begin
                        n0_x = r_x + 6'd1;
                    end
                end
                ST_LEFT: n0_state = ST_PIX;
                ST_PIX: begin
                    n0_col = col1;
                    if (col1 >= i_width || r_fend) begin
                        if (r_fend && col1 < i_width) n0_state = ST_FILL;
                        else if (i_pad)               n0_state = ST_RIGHT;
                        else                          row_done = 1'b1;
                    end else begin
                        n0_state = ST_IDLE;
                    end
                end
                ST_FILL: begin
                    n0_col = col1;
                    if (col1 >= i_width) begin
                        if (i_pad) n0_state = ST_RIGHT;
                        else       row_done = 1'b1;
                    end
                end
                ST_RIGHT: row_done = 1'b1;
                ST_BOTTOM: begin
                    if (r_x == pw_m1) begin
                        n0_row   = '0;
                        n0_state = ST_IDLE;
                    end else begin
                        n0_x = r_x + 6'd1;
                    end
                end
                default: n0_state = ST_IDLE;
            endcase
            if (row_done) begin
                n0_col = '0;
                if (r_row < ROW_SAT) n0_row = r_row + 11'd1;
                if (r_fend && i_pad) begin
                    n0_state = ST_BOTTOM;
                    n0_x     = '0;
                end else if (r_fend) begin
                    n0_row   = '0;
                    n0_state = ST_IDLE;
                end else begin
                    n0_state = ST_IDLE;
                end
            end
        end
    end

    // Start a new beat once the previous one has issued its last feed.
    always_comb begin
        n_state = n0_state;
        n_row   = n0_row;
        n_col   = n0_col;
        n_x     = n0_x;
        n_pix   = r_pix;
        n_fend  = r_fend;
        if (i_acc) begin
            n_pix  = i_pixel;
            n_fend = i_frame_end;
            if (i_pad && n0_row == '0 && n0_col == '0) begin
                n_state = ST_TOP;
                n_x     = '0;
            end else if (i_pad && n0_col == '0) begin
                n_state = ST_LEFT;
            end else begin
                n_state = ST_PIX;
            end
        end
    end

    always_comb begin
        o_ready     = (n0_state == ST_IDLE);
        o_feed.vld  = (r_state != ST_IDLE);
        o_feed.pix  = (r_state == ST_PIX) ? r_pix : 8'd0;
        o_feed.y    = (r_state == ST_TOP) ? 11'd0 : r_row;
        o_feed.last = (n0_state == ST_IDLE);
        o_feed.fend = r_fend;
        case (r_state)
            ST_TOP, ST_BOTTOM: o_feed.x = r_x;
            ST_LEFT:           o_feed.x = 6'd0;
            default:           o_feed.x = r_col + {5'd0, i_pad};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_x     <= '0;
            r_fend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_x     <= n_x;
            r_fend  <= n_fend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end
endmodule

[sv/s2dc_checker.sv]
// Port-level checks for the strided 2-D convolution core, attached by bind.
// Depends on strided_2d_convolution_core and the s2dc channel interfaces.
module s2dc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [27:0] out_value,
    input logic        out_run_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_run_last))
        else $error("stalled result beat changed");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> in_ready)
        else $error("input not ready right after reset");
endmodule

bind strided_2d_convolution_core s2dc_checker u_s2dc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_ready     (i_pix.ready),
    .out_valid    (o_res.valid),
    .out_ready    (o_res.ready),
    .out_value    (o_res.value),
    .out_run_last (o_res.run_last)
);
